@@ hdl/lfr_pkg.sv @@
// ----------------------------------------------------------------------------
// lfr_pkg
// Shared types and constants for the load-cell frame receiver.
// ----------------------------------------------------------------------------
package lfr_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int BYTE_W   = 8;
    localparam int LOAD_W   = 24;
    localparam int WEIGHT_W = 48;
    localparam int CFG_W    = 32;
    localparam int CNT_W    = 32;
    localparam int BSG_W    = 3;
    localparam int PROD_W   = CFG_W + LOAD_W;      // slope * load, exact
    localparam int SUM_W    = PROD_W + 1;          // plus offset, exact
    localparam int APB_ADDR_W = 4;

    localparam logic [BYTE_W-1:0] FRAME_PREFIX = 8'hAA;
    localparam logic [BSG_W-1:0]  BSG_MAX      = 3'd7;
    localparam logic [BSG_W-1:0]  FRAME_LEN    = 3'd5;

    localparam logic [CFG_W-1:0] CAL_GAIN_RST  = 32'd65536;
    localparam logic [CFG_W-1:0] CAL_OFFSET_RST = 32'd0;
    localparam logic [CFG_W-1:0] TIMEOUT_RST   = 32'd1000;
    localparam logic [CFG_W-1:0] RESET_TICKS_RST = 32'd100;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_RUN   = 2'd1,
        MODE_FAULT = 2'd2,
        MODE_RESET = 2'd3
    } link_mode_t;

    typedef enum logic [1:0] {
        REG_CAL_GAIN   = 2'd0,
        REG_CAL_OFFSET = 2'd1,
        REG_TIMEOUT    = 2'd2,
        REG_RESET_TICKS = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [CFG_W-1:0] cal_gain;
        logic [CFG_W-1:0] cal_offset;
        logic [CFG_W-1:0] timeout_ticks;
        logic [CFG_W-1:0] reset_ticks;
    } lfr_cfg_t;

    // one classified item, handed from front to back
    typedef struct packed {
        logic              frame_ok;
        logic [LOAD_W-1:0] load_raw;
        logic              connected;
        logic              shield_enable;
        logic [CNT_W-1:0]  trip_count;
        link_mode_t        link_mode;
    } lfr_entry_t;

endpackage

@@ hdl/lfr_front.sv @@
// ----------------------------------------------------------------------------
// lfr_front
// Byte window, frame check and link state machine; one beat per cycle while the queue has room.
// ----------------------------------------------------------------------------
module lfr_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [lfr_pkg::BYTE_W-1:0]  in_byte,
    input  logic                        in_tick,
    input  lfr_pkg::lfr_cfg_t           cfg,
    output logic                        push_valid,
    output lfr_pkg::lfr_entry_t         push_entry,
    input  logic                        push_ready
);
    import lfr_pkg::*;

    link_mode_t              mode_reg, mode_next;
    logic [BYTE_W-1:0]       win_reg [4];
    logic [BYTE_W-1:0]       win_next [4];
    logic [BSG_W-1:0]        bsg_reg, bsg_next;
    logic [CNT_W-1:0]        tcnt_reg, tcnt_next;
    logic [CNT_W-1:0]        rcnt_reg, rcnt_next;
    logic [CNT_W-1:0]        fcnt_reg, fcnt_next;
    logic [LOAD_W-1:0]       load_reg, load_next;
    logic                    conn_reg, conn_next;
    logic                    shield_reg, shield_next;

    logic                    take, is_idle, byte_take, good;
    logic [CNT_W-1:0]        tcnt_base, tcnt_inc, rcnt_inc;
    logic                    timeout_hit, reset_hit;
    logic [BSG_W-1:0]        bsg_inc;
    logic [BYTE_W-1:0]       sum8;

    assign in_ready   = push_ready;
    assign take       = in_valid && push_ready;
    assign is_idle    = (mode_reg == MODE_IDLE);
    assign byte_take  = take && !in_tick && (is_idle || mode_reg == MODE_RUN);

    // idle entry clears the timeout before the item is handled
    assign tcnt_base   = is_idle ? '0 : tcnt_reg;
    assign tcnt_inc    = (&tcnt_base) ? tcnt_base : tcnt_base + 1'b1;
    assign timeout_hit = (tcnt_inc >= cfg.timeout_ticks);
    assign rcnt_inc    = (&rcnt_reg) ? rcnt_reg : rcnt_reg + 1'b1;
    assign reset_hit   = (rcnt_inc >= cfg.reset_ticks);

    assign bsg_inc = (bsg_reg == BSG_MAX) ? bsg_reg : bsg_reg + 1'b1;
    // frame under test: win_reg[0..3], then in_byte; oldest is the prefix
    assign sum8 = win_reg[1] + win_reg[2] + win_reg[3];
    assign good = byte_take && (win_reg[0] == FRAME_PREFIX) && (bsg_inc >= FRAME_LEN)
                  && (sum8 == in_byte);

    always_comb begin
        mode_next = mode_reg;
        case (mode_reg)
            MODE_IDLE: begin
                if (take && in_tick) begin
                    mode_next = timeout_hit ? MODE_FAULT : MODE_RUN;
                end else if (take) begin
                    mode_next = MODE_RUN;
                end
            end
            MODE_RUN: begin
                if (take && in_tick && timeout_hit) begin
                    mode_next = MODE_FAULT;
                end
            end
            MODE_FAULT: begin
                if (take && in_tick) begin
                    mode_next = MODE_RESET;
                end
            end
            MODE_RESET: begin
                if (take && in_tick && reset_hit) begin
                    mode_next = MODE_IDLE;
                end
            end
            default: mode_next = MODE_IDLE;
        endcase
    end

    always_comb begin
        win_next    = win_reg;
        bsg_next    = bsg_reg;
        tcnt_next   = tcnt_reg;
        rcnt_next   = rcnt_reg;
        fcnt_next   = fcnt_reg;
        load_next   = load_reg;
        conn_next   = conn_reg;
        shield_next = shield_reg;
        if (take && in_tick) begin
            case (mode_reg)
                MODE_IDLE, MODE_RUN: begin
                    conn_next = is_idle ? 1'b0 : conn_reg;
                    tcnt_next = tcnt_inc;
                end
                MODE_FAULT: begin
                    fcnt_next   = fcnt_reg + 1'b1;
                    conn_next   = 1'b0;
                    shield_next = 1'b0;
                    rcnt_next   = '0;
                end
                MODE_RESET: begin
                    rcnt_next = rcnt_inc;
                    if (reset_hit) begin
                        shield_next = 1'b1;
                    end
                end
                default: ;
            endcase
        end else if (byte_take) begin
            conn_next   = is_idle ? 1'b0 : conn_reg;
            tcnt_next   = tcnt_base;
            bsg_next    = bsg_inc;
            win_next[0] = win_reg[1];
            win_next[1] = win_reg[2];
            win_next[2] = win_reg[3];
            win_next[3] = in_byte;
            if (good) begin
                load_next = {win_reg[1], win_reg[2], win_reg[3]};
                conn_next = 1'b1;
                tcnt_next = '0;
                bsg_next  = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_IDLE;
            win_reg    <= '{default: '0};
            bsg_reg    <= '0;
            tcnt_reg   <= '0;
            rcnt_reg   <= '0;
            fcnt_reg   <= '0;
            load_reg   <= '0;
            conn_reg   <= 1'b0;
            shield_reg <= 1'b1;
        end else begin
            mode_reg   <= mode_next;
            win_reg    <= win_next;
            bsg_reg    <= bsg_next;
            tcnt_reg   <= tcnt_next;
            rcnt_reg   <= rcnt_next;
            fcnt_reg   <= fcnt_next;
            load_reg   <= load_next;
            conn_reg   <= conn_next;
            shield_reg <= shield_next;
        end
    end

    assign push_valid               = take;
    assign push_entry.frame_ok      = good;
    assign push_entry.load_raw      = load_next;
    assign push_entry.connected     = conn_next;
    assign push_entry.shield_enable = shield_next;
    assign push_entry.trip_count    = fcnt_next;
    assign push_entry.link_mode     = mode_next;

endmodule

@@ hdl/lfr_queue.sv @@
// ----------------------------------------------------------------------------
// lfr_queue
// Short first-in first-out queue of classified entries between front and back.
// ----------------------------------------------------------------------------
module lfr_queue #(
    parameter int DEPTH = lfr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push_valid,
    output logic                push_ready,
    input  lfr_pkg::lfr_entry_t push_entry,
    output logic                pop_valid,
    input  logic                pop_ready,
    output lfr_pkg::lfr_entry_t pop_entry
);
    import lfr_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_QW = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_QW-1:0] CNT_FULL = CNT_QW'(DEPTH);

    lfr_entry_t         mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_QW-1:0]  count_reg, count_next;
    logic               do_push, do_pop;

    assign push_ready = (count_reg != CNT_FULL);
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

@@ hdl/lfr_back.sv @@
// ----------------------------------------------------------------------------
// lfr_back
// Weight calibration: multiply stage, then offset add and 48-bit saturation
// into the output register.
// ----------------------------------------------------------------------------
module lfr_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  lfr_pkg::lfr_cfg_t             cfg,
    input  logic                          pop_valid,
    output logic                          pop_ready,
    input  lfr_pkg::lfr_entry_t           pop_entry,
    output logic                          out_valid,
    input  logic                          out_ready,
    output lfr_pkg::lfr_entry_t           out_entry,
    output logic [lfr_pkg::WEIGHT_W-1:0]  out_weight
);
    import lfr_pkg::*;

    logic                   a_vld_reg;
    lfr_entry_t             a_ent_reg;
    logic signed [PROD_W-1:0] a_prod_reg;
    logic                   o_vld_reg;
    lfr_entry_t             o_ent_reg;
    logic [WEIGHT_W-1:0]    o_weight_reg, o_weight_next;

    logic                   a_load, o_load;
    logic signed [CFG_W-1:0]  slope_s, offset_s;
    logic signed [LOAD_W-1:0] load_s;
    logic signed [PROD_W-1:0] prod_c;
    logic signed [SUM_W-1:0]  sum_c;
    logic                   sat_hi, sat_lo;
    logic [WEIGHT_W-1:0]    sat_c;

    assign o_load    = a_vld_reg && (!o_vld_reg || out_ready);
    assign a_load    = pop_valid && (!a_vld_reg || o_load);
    assign pop_ready = !a_vld_reg || o_load;

    assign slope_s  = cfg.cal_gain;
    assign offset_s = cfg.cal_offset;
    assign load_s   = pop_entry.load_raw;
    assign prod_c   = slope_s * load_s;

    assign sum_c  = SUM_W'(a_prod_reg) + SUM_W'(offset_s);
    assign sat_hi = !sum_c[SUM_W-1] && (|sum_c[SUM_W-2:WEIGHT_W-1]);
    assign sat_lo = sum_c[SUM_W-1] && !(&sum_c[SUM_W-2:WEIGHT_W-1]);
    always_comb begin
        if (sat_hi) begin
            sat_c = {1'b0, {(WEIGHT_W-1){1'b1}}};
        end else if (sat_lo) begin
            sat_c = {1'b1, {(WEIGHT_W-1){1'b0}}};
        end else begin
            sat_c = sum_c[WEIGHT_W-1:0];
        end
    end
    // the output register doubles as the last-weight holder
    assign o_weight_next = a_ent_reg.frame_ok ? sat_c : o_weight_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg    <= 1'b0;
            o_vld_reg    <= 1'b0;
            o_weight_reg <= '0;
        end else begin
            if (a_load) begin
                a_vld_reg <= 1'b1;
            end else if (o_load) begin
                a_vld_reg <= 1'b0;
            end
            if (o_load) begin
                o_vld_reg    <= 1'b1;
                o_weight_reg <= o_weight_next;
            end else if (out_ready) begin
                o_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (a_load) begin
            a_ent_reg  <= pop_entry;
            a_prod_reg <= prod_c;
        end
        if (o_load) begin
            o_ent_reg <= a_ent_reg;
        end
    end

    assign out_valid  = o_vld_reg;
    assign out_entry  = o_ent_reg;
    assign out_weight = o_weight_reg;

endmodule

@@ hdl/loadcell_frame_receiver.sv @@
// ----------------------------------------------------------------------------
// loadcell_frame_receiver
// Load-cell serial link receiver: frame check with additive checksum, link
// supervision on timer ticks, and calibrated weight output.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake          payload
//  s_        in   s_tvalid/s_tready  s_tdata = rx_byte, s_tuser = cmd (1 = tick)
//  m_        out  m_tvalid/m_tready  m_tdata = status word, m_tuser = frame_ok
//  apb       in   psel/penable/...   4 x 32-bit registers at 0x0, 0x4, 0x8, 0xC
//
//  One beat per cycle sustained while m_tready stays high. An accepted beat
//  reaches m_ through these registers in order: the front writes the queue
//  as the beat is accepted, the multiply stage takes it from the queue, and
//  the add and saturate stage loads the output register that drives m_.
//  Reset is synchronous (aresetn low); no memory clearing pass, s_tready is
//  high once reset is released.
//  m_tready low fills the output register, multiply stage and QUEUE_DEPTH-entry
//  queue (four by default), then s_tready drops; the front and back stall independently.
//
// ----------------------------------------------------------------------------
module loadcell_frame_receiver #(
    parameter int QUEUE_DEPTH = lfr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input beats
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // [7:0] rx_byte
    input  logic                              s_tuser,   // [0] cmd
    // result beats
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [23:0] load_raw, [71:24] weight, [72] connected, [73] shield_enable,
    // [105:74] trip_count, [107:106] link_mode, [111:108] zero
    output logic [111:0]                      m_tdata,
    output logic                              m_tuser,   // [0] frame_ok
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lfr_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import lfr_pkg::*;

    lfr_cfg_t    cfg_reg;
    reg_idx_t    reg_idx;
    logic        cfg_wr;

    logic        push_valid, push_ready;
    lfr_entry_t  push_entry;
    logic        pop_valid, pop_ready;
    lfr_entry_t  pop_entry;
    lfr_entry_t  out_entry;
    logic [WEIGHT_W-1:0] out_weight;

    // ---------------------------------------------------------------- APB
    // Writes land on the access phase; pready is tied high so there are no
    // wait states. Only the word index matters, byte lanes are ignored.
    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.cal_gain      <= CAL_GAIN_RST;
            cfg_reg.cal_offset    <= CAL_OFFSET_RST;
            cfg_reg.timeout_ticks <= TIMEOUT_RST;
            cfg_reg.reset_ticks   <= RESET_TICKS_RST;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_CAL_GAIN:    cfg_reg.cal_gain      <= pwdata;
                REG_CAL_OFFSET:  cfg_reg.cal_offset    <= pwdata;
                REG_TIMEOUT:     cfg_reg.timeout_ticks <= pwdata;
                REG_RESET_TICKS: cfg_reg.reset_ticks   <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_CAL_GAIN:    prdata = cfg_reg.cal_gain;
            REG_CAL_OFFSET:  prdata = cfg_reg.cal_offset;
            REG_TIMEOUT:     prdata = cfg_reg.timeout_ticks;
            REG_RESET_TICKS: prdata = cfg_reg.reset_ticks;
            default:         prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------- front
    // Window shift, checksum test and link state machine, all settled in the
    // cycle the beat is accepted; its result snapshot goes to the queue.
    lfr_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_byte    (s_tdata),
        .in_tick    (s_tuser),
        .cfg        (cfg_reg),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .push_ready (push_ready)
    );

    // ---------------------------------------------------------------- queue
    lfr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    // ---------------------------------------------------------------- back
    // slope * load (32 x 24 signed) in one stage, offset add and clamp to
    // 48 bits in the next, straight into the output register.
    lfr_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_entry  (out_entry),
        .out_weight (out_weight)
    );

    // ---------------------------------------------------------------- result
    assign m_tuser = out_entry.frame_ok;
    assign m_tdata = {4'b0000,
                      out_entry.link_mode,
                      out_entry.trip_count,
                      out_entry.shield_enable,
                      out_entry.connected,
                      out_weight,
                      out_entry.load_raw};

endmodule
